// ----- src/tpwpm_pkg.sv -----
// Shared types and constants of the three-phase window power meter.
// No dependencies.
package tpwpm_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COUNT_WIDTH_DEF  = 12;

  localparam int LEN_W  = 12;
  localparam int LVL_W  = 16;
  localparam int CFG_W  = 16;
  localparam int WIN_W  = 16;
  localparam int TIME_W = 32;

  localparam logic [LEN_W-1:0] WINDOW_LENGTH_RST  = 12'd100;
  localparam logic [LVL_W-1:0] CLIP_THRESHOLD_RST = 16'd20794;
  localparam logic [LVL_W-1:0] RMS_LOW_RST        = 16'd13248;
  localparam logic [LVL_W-1:0] RMS_HIGH_RST       = 16'd16192;

  localparam logic [1:0] REG_WINDOW_LENGTH  = 2'd0;
  localparam logic [1:0] REG_CLIP_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_RMS_LOW        = 2'd2;
  localparam logic [1:0] REG_RMS_HIGH       = 2'd3;

  localparam logic KIND_CLIP    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic       take;
    logic       accum;
    logic [1:0] phase;
    logic       load_clip;
    logic       load_sum;
    logic       out_last;
    logic       div_init;
    logic       div_step;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       close_window;
  } cmd_t;

  typedef struct packed {
    logic [2:0] clip_hit;
    logic       win_end;
  } stat_t;

endpackage

// ----- src/tpwpm_datapath.sv -----
// Datapath: config registers, window accumulators, shared divider and square root,
// output register. Depends on tpwpm_pkg.
module tpwpm_datapath import tpwpm_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [CFG_W-1:0]               cfg_data,
  input  logic signed [SAMPLE_WIDTH-1:0] phase_a,
  input  logic signed [SAMPLE_WIDTH-1:0] phase_b,
  input  logic signed [SAMPLE_WIDTH-1:0] phase_c,
  input  logic [TIME_W-1:0]              time_stamp,
  input  cmd_t                           cmd,
  output stat_t                          stat,
  output logic                           kind,
  output logic [1:0]                     phase,
  output logic [WIN_W-1:0]               window_number,
  output logic signed [SAMPLE_WIDTH-1:0] sample_value,
  output logic [TIME_W-1:0]              event_time,
  output logic [SAMPLE_WIDTH-1:0]        rms,
  output logic [SAMPLE_WIDTH-1:0]        peak_to_peak,
  output logic signed [SAMPLE_WIDTH-1:0] mean_level,
  output logic                           out_of_tolerance,
  output logic                           last
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int CW    = COUNT_WIDTH;
  localparam int SQ_W  = 2 * SW + CW;
  localparam int SUM_W = SW + CW;
  localparam int CMP_W = (CW > LEN_W) ? CW : LEN_W;

  logic [LEN_W-1:0] window_length;
  logic [LVL_W-1:0] clip_threshold;
  logic [LVL_W-1:0] rms_low_limit;
  logic [LVL_W-1:0] rms_high_limit;

  logic signed [SW-1:0]    smp [3];
  logic [TIME_W-1:0]       ts;
  logic [SW-1:0]           mag [3];
  logic [SQ_W-1:0]         square_sums [3];
  logic signed [SUM_W-1:0] plain_sums [3];
  logic signed [SW-1:0]    phase_minimum [3];
  logic signed [SW-1:0]    phase_maximum [3];
  logic [CW-1:0]           sample_count;
  logic [CW-1:0]           n_reg;
  logic [CW-1:0]           n_next;
  logic [WIN_W-1:0]        window_index;
  logic                    win_end;
  logic                    win_end_next;

  logic [SQ_W-1:0]  dq;
  logic [CW-1:0]    dr;
  logic [SQ_W-1:0]  sq;
  logic [CW-1:0]    sr;
  logic             dc_neg;
  logic [CW:0]      dt;
  logic [CW:0]      st;
  logic             dge;
  logic             sge;
  logic [SUM_W-1:0] abs_sum;

  logic [2*SW-1:0]  rad;
  logic [SW+1:0]    srem;
  logic [SW-1:0]    root;
  logic [SW+1:0]    rem_shift;
  logic [SW+1:0]    trial;
  logic             rge;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length  <= WINDOW_LENGTH_RST;
      clip_threshold <= CLIP_THRESHOLD_RST;
      rms_low_limit  <= RMS_LOW_RST;
      rms_high_limit <= RMS_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH:  window_length  <= cfg_data[LEN_W-1:0];
        REG_CLIP_THRESHOLD: clip_threshold <= cfg_data[LVL_W-1:0];
        REG_RMS_LOW:        rms_low_limit  <= cfg_data[LVL_W-1:0];
        REG_RMS_HIGH:       rms_high_limit <= cfg_data[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int f = 0; f < 3; f++) begin
      mag[f] = smp[f][SW-1] ? SW'(~smp[f] + 1'b1) : SW'(smp[f]);
      stat.clip_hit[f] = 32'(mag[f]) >= 32'(clip_threshold);
    end
    stat.win_end = win_end;
    n_next = sample_count + CW'(1);
    win_end_next = (CMP_W'(n_next) >= CMP_W'(window_length)) || (n_next == {CW{1'b1}});
    abs_sum = plain_sums[cmd.phase][SUM_W-1] ? SUM_W'(-plain_sums[cmd.phase])
                                             : SUM_W'(plain_sums[cmd.phase]);
    dt  = {dr, dq[SQ_W-1]};
    st  = {sr, sq[SQ_W-1]};
    dge = dt >= {1'b0, n_reg};
    sge = st >= {1'b0, n_reg};
    rem_shift = {srem[SW-1:0], rad[2*SW-1:2*SW-2]};
    trial     = {root, 2'b01};
    rge       = rem_shift >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      window_index <= '0;
      win_end      <= 1'b0;
      for (int f = 0; f < 3; f++) begin
        square_sums[f] <= '0;
        plain_sums[f]  <= '0;
      end
    end else begin
      if (cmd.accum) begin
        for (int f = 0; f < 3; f++) begin
          square_sums[f] <= square_sums[f] + SQ_W'((2*SW)'(mag[f]) * (2*SW)'(mag[f]));
          plain_sums[f]  <= plain_sums[f] + SUM_W'(smp[f]);
        end
        sample_count <= win_end_next ? '0 : n_next;
        win_end      <= win_end_next;
      end
      if (cmd.close_window) begin
        for (int f = 0; f < 3; f++) begin
          square_sums[f] <= '0;
          plain_sums[f]  <= '0;
        end
        window_index <= window_index + WIN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      smp[0] <= phase_a;
      smp[1] <= phase_b;
      smp[2] <= phase_c;
      ts     <= time_stamp;
    end
    if (cmd.accum) begin
      n_reg <= n_next;
      for (int f = 0; f < 3; f++) begin
        if (sample_count == '0) begin
          phase_minimum[f] <= smp[f];
          phase_maximum[f] <= smp[f];
        end else begin
          if (smp[f] < phase_minimum[f]) phase_minimum[f] <= smp[f];
          if (smp[f] > phase_maximum[f]) phase_maximum[f] <= smp[f];
        end
      end
    end
    if (cmd.div_init) begin
      dq     <= square_sums[cmd.phase];
      sq     <= SQ_W'(abs_sum);
      dr     <= '0;
      sr     <= '0;
      dc_neg <= plain_sums[cmd.phase][SUM_W-1];
    end else if (cmd.div_step) begin
      dr <= dge ? CW'(dt - {1'b0, n_reg}) : dt[CW-1:0];
      sr <= sge ? CW'(st - {1'b0, n_reg}) : st[CW-1:0];
      dq <= {dq[SQ_W-2:0], dge};
      sq <= {sq[SQ_W-2:0], sge};
    end
    if (cmd.sqrt_init) begin
      rad  <= dq[2*SW-1:0];
      srem <= '0;
      root <= '0;
    end else if (cmd.sqrt_step) begin
      rad  <= {rad[2*SW-3:0], 2'b00};
      srem <= rge ? rem_shift - trial : rem_shift;
      root <= {root[SW-2:0], rge};
    end
    if (cmd.load_clip) begin
      kind             <= KIND_CLIP;
      phase            <= cmd.phase;
      window_number    <= window_index;
      sample_value     <= smp[cmd.phase];
      event_time       <= ts;
      rms              <= '0;
      peak_to_peak     <= '0;
      mean_level       <= '0;
      out_of_tolerance <= 1'b0;
      last             <= cmd.out_last;
    end else if (cmd.load_sum) begin
      kind             <= KIND_SUMMARY;
      phase            <= cmd.phase;
      window_number    <= window_index;
      sample_value     <= '0;
      event_time       <= '0;
      rms              <= root;
      peak_to_peak     <= SW'(phase_maximum[cmd.phase] - phase_minimum[cmd.phase]);
      mean_level       <= dc_neg ? SW'(-sq[SW-1:0]) : SW'(sq[SW-1:0]);
      out_of_tolerance <= (32'(root) < 32'(rms_low_limit)) ||
                          (32'(root) > 32'(rms_high_limit));
      last             <= cmd.out_last;
    end
  end

endmodule

// ----- src/tpwpm_ctrl.sv -----
// Controller: sequences sample intake, clip events and the per-phase window close.
// Depends on tpwpm_pkg.
module tpwpm_ctrl import tpwpm_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam int SQ_W  = 2 * SAMPLE_WIDTH + COUNT_WIDTH;
  localparam int STP_W = $clog2(SQ_W + 1);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b00000001,
    S_ACC       = 8'b00000010,
    S_CLIP      = 8'b00000100,
    S_DIV_INIT  = 8'b00001000,
    S_DIV       = 8'b00010000,
    S_SQRT_INIT = 8'b00100000,
    S_SQRT      = 8'b01000000,
    S_EMIT      = 8'b10000000
  } state_t;

  state_t           state, state_next;
  logic [1:0]       ph, ph_next;
  logic [STP_W-1:0] step, step_next;
  logic             can_load;
  logic             hit;
  logic             later_hits;
  logic             out_valid_next;

  always_comb begin
    state_next = state;
    ph_next    = ph;
    step_next  = step;
    cmd        = '0;
    cmd.phase  = ph;
    in_ready   = (state == S_IDLE);
    can_load   = !out_valid || out_ready;
    hit        = stat.clip_hit[ph];
    later_hits = (ph == 2'd0) ? (stat.clip_hit[1] || stat.clip_hit[2])
               : (ph == 2'd1) ? stat.clip_hit[2] : 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.accum  = 1'b1;
        ph_next    = 2'd0;
        state_next = S_CLIP;
      end
      S_CLIP: begin
        if (!hit || can_load) begin
          cmd.load_clip = hit;
          cmd.out_last  = !later_hits && !stat.win_end;
          if (ph == 2'd2) begin
            ph_next    = 2'd0;
            state_next = stat.win_end ? S_DIV_INIT : S_IDLE;
          end else begin
            ph_next = ph + 2'd1;
          end
        end
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        step_next    = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step == STP_W'(SQ_W - 1)) begin
          state_next = S_SQRT_INIT;
        end else begin
          step_next = step + STP_W'(1);
        end
      end
      S_SQRT_INIT: begin
        cmd.sqrt_init = 1'b1;
        step_next     = '0;
        state_next    = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (step == STP_W'(SAMPLE_WIDTH - 1)) begin
          state_next = S_EMIT;
        end else begin
          step_next = step + STP_W'(1);
        end
      end
      S_EMIT: begin
        if (can_load) begin
          cmd.load_sum = 1'b1;
          cmd.out_last = (ph == 2'd2);
          if (ph == 2'd2) begin
            cmd.close_window = 1'b1;
            ph_next          = 2'd0;
            state_next       = S_IDLE;
          end else begin
            ph_next    = ph + 2'd1;
            state_next = S_DIV_INIT;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
    out_valid_next = (cmd.load_clip || cmd.load_sum) ? 1'b1 : (out_ready ? 1'b0 : out_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ph        <= 2'd0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ph        <= ph_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_clip || cmd.load_sum) |-> (!out_valid || out_ready))
    else $error("result register overwritten while held");

  a_close_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_INIT) |-> stat.win_end)
    else $error("window close without window end");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    ph != 2'd3)
    else $error("phase counter out of range");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("state not one-hot");

endmodule

// ----- src/three_phase_window_power_meter_unit.sv -----
// Three-phase window power meter, top level.
// Depends on tpwpm_pkg, tpwpm_ctrl and tpwpm_datapath.
//
// Input channel (in_valid/in_ready) takes one request: phase_a..c and time_stamp.
// Output channel (out_valid/out_ready) returns result items, one per handshake.
// Per sample, each phase whose magnitude is at or above clip_threshold yields a
// clip event (A, B, C order). The sample that closes a window then yields three
// summaries (rms, peak_to_peak, mean_level, out_of_tolerance). last marks the
// final result of a request. The configuration port (cfg_we, cfg_index, cfg_data)
// writes a register; write only while idle.
// A sample without window close passes intake, accumulate and three clip slots.
// A window close adds per phase a divider init and shift-subtract divider pass,
// a square root init and bit-serial square root, and a load/emit step, all on
// the divider and square-root unit shared by the three phases.
// A single output register holds the pending result; when the receiver stalls
// the sequencer holds until it is taken. Reset restores the register defaults,
// clears the accumulators, sample count and window index, and drops out_valid.
module three_phase_window_power_meter_unit import tpwpm_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [CFG_W-1:0]               cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] phase_a,
  input  logic signed [SAMPLE_WIDTH-1:0] phase_b,
  input  logic signed [SAMPLE_WIDTH-1:0] phase_c,
  input  logic [TIME_W-1:0]              time_stamp,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           kind,
  output logic [1:0]                     phase,
  output logic [WIN_W-1:0]               window_number,
  output logic signed [SAMPLE_WIDTH-1:0] sample_value,
  output logic [TIME_W-1:0]              event_time,
  output logic [SAMPLE_WIDTH-1:0]        rms,
  output logic [SAMPLE_WIDTH-1:0]        peak_to_peak,
  output logic signed [SAMPLE_WIDTH-1:0] mean_level,
  output logic                           out_of_tolerance,
  output logic                           last
);

  cmd_t  cmd;
  stat_t stat;

  tpwpm_ctrl #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tpwpm_datapath #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .phase_a         (phase_a),
    .phase_b         (phase_b),
    .phase_c         (phase_c),
    .time_stamp      (time_stamp),
    .cmd             (cmd),
    .stat            (stat),
    .kind            (kind),
    .phase           (phase),
    .window_number   (window_number),
    .sample_value    (sample_value),
    .event_time      (event_time),
    .rms             (rms),
    .peak_to_peak    (peak_to_peak),
    .mean_level      (mean_level),
    .out_of_tolerance(out_of_tolerance),
    .last            (last)
  );

endmodule
